### rtl/bdrc_pkg.sv
// Package: shared constants, types and helpers of the block dedup compressor.
`default_nettype none
package bdrc_pkg;
    localparam int BLOCK_DIGITS = 63;
    localparam int BLOCK_BYTES  = BLOCK_DIGITS / 3;
    localparam int DICT_ENTRIES = 1024;
    localparam int POS_W        = $clog2(BLOCK_BYTES + 1);
    localparam int ID_W         = $clog2(DICT_ENTRIES);
    localparam int CNT_W        = ID_W + 1;
    localparam int MEM_DEPTH    = DICT_ENTRIES * BLOCK_BYTES;
    localparam int MEM_AW       = $clog2(MEM_DEPTH);
    localparam logic [31:0] HASH_INIT = 32'd5381;
    localparam logic [31:0] RUN_MAX   = 32'hFFFF_FFFF;
    localparam logic [10:0] LIMIT_RESET = 11'd1024;
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_RUN   = 2'd1;
    localparam logic [1:0] KIND_ABORT = 2'd2;
    localparam logic [0:0] REG_LIMIT  = 1'b0;

    typedef struct packed {
        logic [1:0]       kind;
        logic [ID_W-1:0]  block_id;
        logic [7:0]       block_byte;
        logic [4:0]       byte_position;
        logic [31:0]      block_hash;
        logic [31:0]      run_count;
        logic             last_of_item;
    } result_t;

    // datapath commands from the controller
    typedef struct packed {
        logic       take_byte;       // store input byte, fold into hash
        logic       pad_byte;        // store zero, fold into hash
        logic       clear_block;     // restart fill and hash for the next block
        logic       search_start;    // rewind to the first dictionary entry
        logic       hash_rd;         // read the current entry's hash
        logic       byte_rd;         // read the current entry's byte at pos
        logic       pos_step;
        logic       pos_clear;
        logic       entry_next;      // move to the next entry
        logic       set_found;
        logic       emit_load;       // load the result register
        logic [1:0] emit_sel;
        logic       emit_last;
        logic       commit_new;      // bump entry count, open run on the new id
        logic       run_extend;
        logic       run_start_found; // open run on the found id
        logic       clear_stream;    // end of stream or abort
    } dp_cmd_t;

    typedef struct packed {
        logic       block_last;      // next byte completes the block
        logic       block_full;
        logic       at_limit;
        logic       no_more_entries;
        logic       hash_match;
        logic       byte_match;
        logic       last_pos;
        logic       found;
        logic       run_open;
        logic       run_same;
    } dp_sts_t;

    function automatic logic [31:0] hash_byte(input logic [31:0] h, input logic [7:0] b);
        logic [3:0]  d0, d1, d2;
        logic [7:0]  rem;
        logic [15:0] prod;
        logic [31:0] t;
        begin
            // hundreds by compare, tens by reciprocal multiply, units by subtract
            if (b >= 8'd200)
            begin
                d0  = 4'd2;
                rem = b - 8'd200;
            end
            else if (b >= 8'd100)
            begin
                d0  = 4'd1;
                rem = b - 8'd100;
            end
            else
            begin
                d0  = 4'd0;
                rem = b;
            end
            prod = {8'd0, rem} * 16'd205;
            d1   = prod[14:11];
            d2   = 4'(rem - {1'b0, d1, 3'b000} - {3'b000, d1, 1'b0});
            t = (h << 5) + h + {28'd0, d0};
            t = (t << 5) + t + {28'd0, d1};
            t = (t << 5) + t + {28'd0, d2};
            return t;
        end
    endfunction
endpackage
`default_nettype wire

### rtl/bdrc_if.sv
// Interfaces: valid/ready stream channels for input and result items.
`default_nettype none
interface bdrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;
    modport source (output valid, data_byte, final_byte, input ready);
    modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

interface bdrc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [9:0]  block_id;
    logic [7:0]  block_byte;
    logic [4:0]  byte_position;
    logic [31:0] block_hash;
    logic [31:0] run_count;
    logic        last_of_item;
    modport source (output valid, kind, block_id, block_byte, byte_position, block_hash,
                    run_count, last_of_item, input ready);
    modport sink   (input valid, kind, block_id, block_byte, byte_position, block_hash,
                    run_count, last_of_item, output ready);
endinterface
`default_nettype wire

### rtl/bdrc_datapath.sv
// Datapath: block buffer, hash, dictionary memories, run state and result register.
`default_nettype none
module bdrc_datapath
    import bdrc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire dp_cmd_t      cmd,
    output      dp_sts_t      sts,
    input  wire logic [7:0]   in_byte,
    input  wire logic [10:0]  limit,
    output      result_t      res
);
    logic [7:0]        buf_reg [BLOCK_BYTES];
    logic [POS_W-1:0]  fill_reg;
    logic [31:0]       hash_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [ID_W-1:0]   run_id_reg;
    logic [31:0]       run_len_reg;
    logic [CNT_W-1:0]  ent_reg;
    logic [MEM_AW-1:0] base_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              found_reg;
    logic [7:0]        mem_bytes [MEM_DEPTH];
    logic [31:0]       mem_hash  [DICT_ENTRIES];
    logic [7:0]        rd_byte_reg;
    logic [31:0]       rd_hash_reg;
    result_t           res_reg;
    logic [CNT_W-1:0]  lim_eff;
    logic [7:0]        fold_byte;
    logic [ID_W-1:0]   new_id;
    logic [ID_W-1:0]   ent_id;
    logic [MEM_AW-1:0] new_base;
    logic [7:0]        cur_byte;

    assign lim_eff   = (limit > 11'(DICT_ENTRIES)) ? CNT_W'(DICT_ENTRIES) : CNT_W'(limit);
    assign fold_byte = cmd.pad_byte ? 8'd0 : in_byte;
    assign new_id    = count_reg[ID_W-1:0];
    assign ent_id    = ent_reg[ID_W-1:0];
    assign new_base  = MEM_AW'(new_id * BLOCK_BYTES);
    assign cur_byte  = buf_reg[pos_reg];
    assign res       = res_reg;

    always_comb
    begin
        sts.block_last      = (fill_reg == POS_W'(BLOCK_BYTES - 1));
        sts.block_full      = (fill_reg == POS_W'(BLOCK_BYTES));
        sts.at_limit        = (count_reg >= lim_eff);
        sts.no_more_entries = (ent_reg >= count_reg);
        sts.hash_match      = (rd_hash_reg == hash_reg);
        sts.byte_match      = (rd_byte_reg == cur_byte);
        sts.last_pos        = (pos_reg == POS_W'(BLOCK_BYTES - 1));
        sts.found           = found_reg;
        sts.run_open        = (run_len_reg != 32'd0);
        sts.run_same        = found_reg && (run_len_reg != 32'd0) &&
                              (run_id_reg == ent_id) && (run_len_reg != RUN_MAX);
    end

    // dictionary memories: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.emit_load && cmd.emit_sel == KIND_BYTE)
        begin
            mem_bytes[new_base + MEM_AW'(pos_reg)] <= cur_byte;
            mem_hash[new_id] <= hash_reg;
        end
        if (cmd.hash_rd)
            rd_hash_reg <= mem_hash[ent_id];
        if (cmd.byte_rd)
            rd_byte_reg <= mem_bytes[base_reg + MEM_AW'(pos_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_byte || cmd.pad_byte)
            buf_reg[fill_reg] <= fold_byte;
        if (cmd.emit_load)
        begin
            case (cmd.emit_sel)
                KIND_BYTE:
                begin
                    res_reg <= '{KIND_BYTE, new_id, cur_byte, 5'(pos_reg), hash_reg, 32'd0,
                                 cmd.emit_last};
                end
                KIND_RUN:
                begin
                    res_reg <= '{KIND_RUN, run_id_reg, 8'd0, 5'd0, 32'd0, run_len_reg,
                                 cmd.emit_last};
                end
                default:
                begin
                    res_reg <= '{KIND_ABORT, '0, 8'd0, 5'd0, 32'd0, 32'd0, cmd.emit_last};
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            hash_reg    <= HASH_INIT;
            count_reg   <= '0;
            run_id_reg  <= '0;
            run_len_reg <= '0;
            ent_reg     <= '0;
            base_reg    <= '0;
            pos_reg     <= '0;
            found_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clear_block || cmd.clear_stream)
            begin
                fill_reg <= '0;
                hash_reg <= HASH_INIT;
            end
            else if (cmd.take_byte || cmd.pad_byte)
            begin
                fill_reg <= fill_reg + 1'b1;
                hash_reg <= hash_byte(hash_reg, fold_byte);
            end

            if (cmd.search_start)
            begin
                ent_reg  <= '0;
                base_reg <= '0;
            end
            else if (cmd.entry_next)
            begin
                ent_reg  <= ent_reg + 1'b1;
                base_reg <= base_reg + MEM_AW'(BLOCK_BYTES);
            end

            if (cmd.search_start || cmd.entry_next || cmd.pos_clear)
                pos_reg <= '0;
            else if (cmd.pos_step)
                pos_reg <= pos_reg + 1'b1;

            if (cmd.search_start)
                found_reg <= 1'b0;
            else if (cmd.set_found)
                found_reg <= 1'b1;

            if (cmd.clear_stream)
                count_reg <= '0;
            else if (cmd.commit_new)
                count_reg <= count_reg + 1'b1;

            if (cmd.clear_stream)
            begin
                run_id_reg  <= '0;
                run_len_reg <= '0;
            end
            else if (cmd.commit_new)
            begin
                run_id_reg  <= new_id;
                run_len_reg <= 32'd1;
            end
            else if (cmd.run_start_found)
            begin
                run_id_reg  <= ent_id;
                run_len_reg <= 32'd1;
            end
            else if (cmd.run_extend)
                run_len_reg <= run_len_reg + 1'b1;
        end
    end
endmodule
`default_nettype wire

### rtl/bdrc_ctrl.sv
// Controller: sequences byte intake, padding, dictionary search and result emission.
`default_nettype none
module bdrc_ctrl
    import bdrc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    in_final,
    output      logic    in_ready,
    output      logic    out_valid,
    input  wire logic    out_ready,
    input  wire dp_sts_t sts,
    output      dp_cmd_t cmd
);
    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_PAD   = 13'b0000000000010,
        S_CHECK = 13'b0000000000100,
        S_HRD   = 13'b0000000001000,
        S_HCMP  = 13'b0000000010000,
        S_BRD   = 13'b0000000100000,
        S_BCMP  = 13'b0000001000000,
        S_DEC   = 13'b0000010000000,
        S_RUN   = 13'b0000100000000,
        S_BYTES = 13'b0001000000000,
        S_FIN   = 13'b0010000000000,
        S_ABORT = 13'b0100000000000,
        S_DEAD  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   fin_reg, fin_next;
    logic   ov_reg, ov_next;
    logic   out_free;

    // result register can take a new item when empty or being drained
    assign out_free  = !ov_reg || out_ready;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take_byte = 1'b1;
                    fin_next      = in_final;
                    if (in_final)
                        state_next = S_PAD;
                    else if (sts.block_last)
                        state_next = S_CHECK;
                end
            end
            S_PAD:
            begin
                if (sts.block_full)
                    state_next = S_CHECK;
                else
                    cmd.pad_byte = 1'b1;
            end
            S_CHECK:
            begin
                if (sts.at_limit)
                    state_next = S_ABORT;
                else
                begin
                    cmd.search_start = 1'b1;
                    state_next       = S_HRD;
                end
            end
            S_HRD:
            begin
                if (sts.no_more_entries)
                    state_next = S_DEC;
                else
                begin
                    cmd.hash_rd = 1'b1;
                    state_next  = S_HCMP;
                end
            end
            S_HCMP:
            begin
                if (sts.hash_match)
                    state_next = S_BRD;
                else
                begin
                    cmd.entry_next = 1'b1;
                    state_next     = S_HRD;
                end
            end
            S_BRD:
            begin
                cmd.byte_rd = 1'b1;
                state_next  = S_BCMP;
            end
            S_BCMP:
            begin
                if (!sts.byte_match)
                begin
                    cmd.entry_next = 1'b1;
                    state_next     = S_HRD;
                end
                else if (sts.last_pos)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = S_DEC;
                end
                else
                begin
                    cmd.pos_step = 1'b1;
                    state_next   = S_BRD;
                end
            end
            S_DEC:
            begin
                cmd.pos_clear = 1'b1;
                if (sts.run_same)
                begin
                    cmd.run_extend  = 1'b1;
                    cmd.clear_block = 1'b1;
                    state_next      = fin_reg ? S_FIN : S_IDLE;
                end
                else if (sts.run_open)
                    state_next = S_RUN;
                else if (sts.found)
                begin
                    cmd.run_start_found = 1'b1;
                    cmd.clear_block     = 1'b1;
                    state_next          = fin_reg ? S_FIN : S_IDLE;
                end
                else
                    state_next = S_BYTES;
            end
            S_RUN:
            begin
                // close the open run, then open the found id or store a new block
                if (out_free)
                begin
                    cmd.emit_load = 1'b1;
                    cmd.emit_sel  = KIND_RUN;
                    cmd.emit_last = sts.found && !fin_reg;
                    if (sts.found)
                    begin
                        cmd.run_start_found = 1'b1;
                        cmd.clear_block     = 1'b1;
                        state_next          = fin_reg ? S_FIN : S_IDLE;
                    end
                    else
                        state_next = S_BYTES;
                end
            end
            S_BYTES:
            begin
                if (out_free)
                begin
                    cmd.emit_load = 1'b1;
                    cmd.emit_sel  = KIND_BYTE;
                    cmd.emit_last = sts.last_pos && !fin_reg;
                    if (sts.last_pos)
                    begin
                        cmd.commit_new  = 1'b1;
                        cmd.clear_block = 1'b1;
                        state_next      = fin_reg ? S_FIN : S_IDLE;
                    end
                    else
                        cmd.pos_step = 1'b1;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.emit_load    = 1'b1;
                    cmd.emit_sel     = KIND_RUN;
                    cmd.emit_last    = 1'b1;
                    cmd.clear_stream = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_ABORT:
            begin
                if (out_free)
                begin
                    cmd.emit_load    = 1'b1;
                    cmd.emit_sel     = KIND_ABORT;
                    cmd.emit_last    = 1'b1;
                    cmd.clear_stream = 1'b1;
                    state_next       = S_DEAD;
                end
            end
            S_DEAD:
            begin
                // accept and drop every item until reset
                in_ready = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        ov_next = cmd.emit_load ? 1'b1 : (ov_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            ov_reg    <= ov_next;
        end
    end
endmodule
`default_nettype wire

### rtl/block_dedup_rle_compressor.sv
// Top level of the block deduplicating run-length compressor.
//
// Usage: bytes enter on in_ch (data_byte, final_byte) with valid/ready, one
// item per cycle while a block fills. Every 21 bytes form a block; a block
// that final_byte closes early is padded with zero bytes, one per cycle.
// A full block is hashed (djb2 over its 63 digits) and searched in the
// dictionary memory: each stored entry's hash is read and compared, and an
// entry whose hash matches is then compared byte by byte.
// in_ready stays low from a block's last byte until its results are loaded.
// Results then leave one per cycle while the receiver is ready: a kind-1 item
// for a run that the block closes, 21 kind-0 items for a new block, and a
// kind-1 item after final_byte. A full dictionary yields one kind-2 item;
// afterwards input is accepted and dropped until reset. out_ch is driven
// from a result register; a stalled receiver holds the item and stalls the
// controller at its next result. Reset clears all control state; dictionary
// memories need no clearing since only entries below the entry count are
// read. dictionary_limit sits at APB address 0 (reset 1024) and must be
// written only while nothing is in flight; the block does not enforce this.
`default_nettype none
module block_dedup_rle_compressor
    import bdrc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    bdrc_in_if.sink          in_ch,
    bdrc_out_if.source       out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);
    dp_cmd_t      cmd;
    dp_sts_t      sts;
    result_t      res;
    logic [10:0]  limit_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LIMIT) ? {21'd0, limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (psel && penable && pwrite && paddr[2] == REG_LIMIT)
            limit_reg <= pwdata[10:0];
    end

    bdrc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_final(in_ch.final_byte), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .sts(sts), .cmd(cmd)
    );

    bdrc_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .in_byte(in_ch.data_byte), .limit(limit_reg), .res(res)
    );

    assign out_ch.kind          = res.kind;
    assign out_ch.block_id      = res.block_id;
    assign out_ch.block_byte    = res.block_byte;
    assign out_ch.byte_position = res.byte_position;
    assign out_ch.block_hash    = res.block_hash;
    assign out_ch.run_count     = res.run_count;
    assign out_ch.last_of_item  = res.last_of_item;
endmodule
`default_nettype wire

### verif/tb_block_dedup_rle_compressor.sv
// Testbench: block dedup compressor driven with byte streams, checked against a local predictor.
`default_nettype none
module tb_block_dedup_rle_compressor;
    import bdrc_pkg::*;

    // Expected-result store plus a private model of the compressor state.
    class dedup_scoreboard;
        result_t     pending[$];
        int          errors;
        logic [7:0]  blk_buf[BLOCK_BYTES];
        int          fill;
        logic [31:0] hash_acc;
        logic [7:0]  dict_bytes[DICT_ENTRIES][BLOCK_BYTES];
        logic [31:0] dict_hash[DICT_ENTRIES];
        int          entries;
        logic [9:0]  cur_run_id;
        logic [31:0] cur_run_len;
        bit          stopped;
        logic [10:0] limit;

        function new();
            errors = 0;
            stopped = 0;
            limit = LIMIT_RESET;
            restart();
        endfunction

        function void restart();
            foreach (blk_buf[i]) blk_buf[i] = 8'd0;
            fill = 0;
            hash_acc = HASH_INIT;
            entries = 0;
            cur_run_id = '0;
            cur_run_len = '0;
        endfunction

        function logic [31:0] fold_byte(logic [31:0] h, logic [7:0] b);
            h = h * 33 + 32'(b / 100);
            h = h * 33 + 32'((b % 100) / 10);
            h = h * 33 + 32'(b % 10);
            return h;
        endfunction

        function void push(logic [1:0] k, logic [9:0] id, logic [7:0] by, logic [4:0] pos,
                           logic [31:0] hs, logic [31:0] cnt);
            result_t r;
            r.kind = k;
            r.block_id = id;
            r.block_byte = by;
            r.byte_position = pos;
            r.block_hash = hs;
            r.run_count = cnt;
            r.last_of_item = 1'b0;
            pending.push_back(r);
        endfunction

        // Predict the results of one accepted input byte.
        function void note_byte(logic [7:0] b, logic fin);
            int n0;
            int eff;
            int hit_id;
            bit same;
            result_t r;
            n0 = pending.size();
            if (stopped)
                return;
            if (fill < BLOCK_BYTES)
            begin
                blk_buf[fill] = b;
                hash_acc = fold_byte(hash_acc, b);
                fill++;
            end
            if (fill < BLOCK_BYTES && !fin)
                return;
            // pad a short final block with zero bytes
            while (fill < BLOCK_BYTES)
            begin
                blk_buf[fill] = 8'd0;
                hash_acc = fold_byte(hash_acc, 8'd0);
                fill++;
            end
            eff = (limit > DICT_ENTRIES) ? DICT_ENTRIES : int'(limit);
            if (entries >= eff)
            begin
                stopped = 1;
                restart();
                push(KIND_ABORT, '0, '0, '0, '0, '0);
            end
            else
            begin
                hit_id = -1;
                for (int e = 0; e < entries && hit_id < 0; e++)
                begin
                    same = (dict_hash[e] == hash_acc);
                    for (int p = 0; p < BLOCK_BYTES; p++)
                        if (dict_bytes[e][p] != blk_buf[p])
                            same = 0;
                    if (same)
                        hit_id = e;
                end
                if (hit_id >= 0 && cur_run_len != 0 && cur_run_id == 10'(hit_id)
                    && cur_run_len < RUN_MAX)
                    cur_run_len++;
                else
                begin
                    if (cur_run_len != 0)
                        push(KIND_RUN, cur_run_id, '0, '0, '0, cur_run_len);
                    if (hit_id < 0)
                    begin
                        hit_id = entries;
                        dict_bytes[hit_id] = blk_buf;
                        dict_hash[hit_id] = hash_acc;
                        entries++;
                        for (int p = 0; p < BLOCK_BYTES; p++)
                            push(KIND_BYTE, 10'(hit_id), blk_buf[p], 5'(p), hash_acc, '0);
                    end
                    cur_run_id = 10'(hit_id);
                    cur_run_len = 1;
                end
                fill = 0;
                hash_acc = HASH_INIT;
                if (fin)
                begin
                    push(KIND_RUN, cur_run_id, '0, '0, '0, cur_run_len);
                    restart();
                end
            end
            if (pending.size() > n0)
            begin
                r = pending[pending.size() - 1];
                r.last_of_item = 1'b1;
                pending[pending.size() - 1] = r;
            end
        endfunction

        function void cmp_field(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
            end
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_result(result_t got);
            result_t e;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                return;
            end
            e = pending.pop_front();
            cmp_field("kind", 32'(e.kind), 32'(got.kind));
            cmp_field("block_id", 32'(e.block_id), 32'(got.block_id));
            cmp_field("block_byte", 32'(e.block_byte), 32'(got.block_byte));
            cmp_field("byte_position", 32'(e.byte_position), 32'(got.byte_position));
            cmp_field("block_hash", e.block_hash, got.block_hash);
            cmp_field("run_count", e.run_count, got.run_count);
            cmp_field("last_of_item", 32'(e.last_of_item), 32'(got.last_of_item));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bdrc_in_if  in_ch();
    bdrc_out_if out_ch();

    dedup_scoreboard sb = new();

    int  sent_items;
    int  burst_left;
    bit  calm;
    int  stall_cycle;
    int  stall_mode;

    block_dedup_rle_compressor dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver stalls: switch at random between always-ready, a fixed 3-of-4
    // pattern and coin flips so stalls land on every phase of emission.
    always @(negedge clk)
    begin
        if (stall_cycle % 64 == 0)
            stall_mode = int'($urandom_range(0, 2));
        stall_cycle++;
        case (stall_mode)
            0: out_ch.ready = 1'b1;
            1: out_ch.ready = (stall_cycle % 4) != 0;
            default: out_ch.ready = 1'($urandom_range(0, 1));
        endcase
    end

    // Sample results at the rising edge and hand them to the scoreboard.
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.kind = out_ch.kind;
            got.block_id = out_ch.block_id;
            got.block_byte = out_ch.block_byte;
            got.byte_position = out_ch.byte_position;
            got.block_hash = out_ch.block_hash;
            got.run_count = out_ch.run_count;
            got.last_of_item = out_ch.last_of_item;
            sb.check_result(got);
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    // Send one byte; the sender works in bursts with random gaps unless calm.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (!calm)
            begin
                in_ch.valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
        in_ch.valid = 1'b1;
        in_ch.data_byte = b;
        in_ch.final_byte = fin;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_byte(b, fin);
        sent_items++;
        burst_left--;
        @(negedge clk);
    endtask

    // Drop valid, wait out every expected result, then let the block settle.
    task automatic drain();
        int guard;
        in_ch.valid = 1'b0;
        burst_left = 0;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        // a found block that only extends a run leaves no result behind
        repeat (600) @(negedge clk);
    endtask

    task automatic write_limit(input logic [10:0] v);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {REG_LIMIT, 2'b00};
        pwdata = {21'd0, v};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.limit = v;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Pulse reset to leave the stopped state, then restore the limit in use.
    task automatic reset_dut();
        logic [10:0] keep;
        keep = sb.limit;
        @(negedge clk);
        rst_n = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        sb.stopped = 0;
        sb.limit = LIMIT_RESET;
        sb.restart();
        if (keep != LIMIT_RESET)
            write_limit(keep);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // Play one stream of nblk blocks drawn from a small pool of block patterns,
    // so repeats form runs; the last block is sometimes short and gets padded.
    task automatic play_stream(input int nblk, input int pool);
        logic [7:0] pat[4][BLOCK_BYTES];
        logic [7:0] bytes_q[$];
        int         sel;
        int         tail;
        foreach (pat[i, j]) pat[i][j] = pick_byte();
        for (int k = 0; k < nblk; k++)
        begin
            sel = $urandom_range(0, pool - 1);
            tail = BLOCK_BYTES;
            if (k == nblk - 1 && $urandom_range(0, 2) == 0)
                tail = $urandom_range(1, BLOCK_BYTES - 1);
            for (int p = 0; p < tail; p++)
                bytes_q.push_back(pat[sel][p]);
        end
        foreach (bytes_q[i])
            send_byte(bytes_q[i], i == bytes_q.size() - 1);
    endtask

    // Noise: random bytes with the end of stream at a random place.
    task automatic play_noise();
        int len;
        len = $urandom_range(1, 30);
        for (int i = 0; i < len; i++)
            send_byte(pick_byte(), i == len - 1);
    endtask

    task automatic random_phase(input int quota, input int max_blocks);
        int stop_at;
        stop_at = sent_items + quota;
        while (sent_items < stop_at)
        begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
                play_noise();
            else
                play_stream($urandom_range(1, max_blocks), $urandom_range(1, 3));
            if (sb.stopped)
            begin
                drain();
                reset_dut();
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.final_byte = 1'b0;
        out_ch.ready = 1'b0;
        stall_cycle = 0;
        stall_mode = 0;
        sent_items = 0;
        burst_left = 0;
        calm = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: one-byte streams at both byte extremes (heavy padding),
        // then a full block whose last byte also ends the stream.
        send_byte(8'd255, 1'b1);
        send_byte(8'd0, 1'b1);
        for (int i = 0; i < BLOCK_BYTES; i++)
            send_byte((i % 2) ? 8'd255 : 8'(i * 12), i == BLOCK_BYTES - 1);
        drain();

        // Reset limit, then above the dictionary size, then a limit of one.
        random_phase(10, 2);
        drain();
        write_limit(11'h7FF);
        random_phase(10, 2);
        drain();
        write_limit(11'd1);
        random_phase(5, 1);
        drain();

        // Overflow: two distinct blocks against a limit of one, then bytes
        // that the stopped block must ignore.
        write_limit(11'd1);
        for (int i = 0; i < 2 * BLOCK_BYTES; i++)
            send_byte(8'(i + 1), i == 2 * BLOCK_BYTES - 1);
        for (int i = 0; i < 5; i++)
            send_byte(pick_byte(), 1'($urandom_range(0, 1)));
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
        begin
            if (sb.pending.size() != 0)
                $display("%0t: %0d expected results never arrived, expected 0, actual %0d",
                         $time, sb.pending.size(), sb.pending.size());
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
rtl/bdrc_pkg.sv
rtl/bdrc_if.sv
rtl/bdrc_datapath.sv
rtl/bdrc_ctrl.sv
rtl/block_dedup_rle_compressor.sv
verif/tb_block_dedup_rle_compressor.sv
